### rtl/core/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker package
// Shared widths, constants, status codes and word types of the walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int ADDR_W         = 52;
    localparam int VA_USED_W      = 48;
    localparam int S_TDATA_W      = 200;
    localparam int M_TDATA_W      = 112;

    localparam logic [ADDR_W-1:0] PHYS_MASK =
        ADDR_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1);
    localparam logic [ADDR_W-1:0] BASE_LOW_MASK  = ADDR_W'(64'hF);
    localparam logic [ADDR_W-1:0] PAGE_LOW_MASK  = ADDR_W'(64'hFFF);
    localparam logic [ADDR_W-1:0] LARGE_LOW_MASK = ADDR_W'(64'h1FFFFF);

    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;
    localparam logic RESULT_READ   = 1'b0;
    localparam logic RESULT_DONE   = 1'b1;

    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ARG     = 3'd1,
        ST_NOT_PRESENT = 3'd2,
        ST_READ_ERROR  = 3'd3,
        ST_BUSY        = 3'd4,
        ST_UNEXPECTED  = 3'd5
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] table_base;
        logic [63:0] virtual_address;
        logic [63:0] entry_data;
        logic        read_ok;
    } in_word_t;

    typedef struct packed {
        logic              result_kind;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] target_address;
        status_t           status;
        logic              large_mapping;
    } out_word_t;

endpackage

### rtl/core/ptw_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker input stage
// Registers one incoming word and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module ptw_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           advance,
    output logic                           word_valid,
    output ptw_pkg::in_word_t              word
);

    logic                valid_reg;
    logic                valid_next;
    ptw_pkg::in_word_t   word_reg;

    assign s_tready   = !valid_reg || advance;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg.kind            <= s_tuser;
            word_reg.table_base      <= s_tdata[63:0];
            word_reg.virtual_address <= s_tdata[127:64];
            word_reg.entry_data      <= s_tdata[191:128];
            word_reg.read_ok         <= s_tdata[192];
        end
    end

endmodule

### rtl/core/ptw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker step logic
// Holds the walk state and turns one word into its result word.
// ----------------------------------------------------------------------------
module ptw_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  ptw_pkg::in_word_t  word,
    output ptw_pkg::out_word_t result
);

    logic                            active_reg;
    logic                            active_next;
    ptw_pkg::level_t                 level_reg;
    ptw_pkg::level_t                 level_next;
    logic [ptw_pkg::VA_USED_W-1:0]   saved_reg;
    logic [ptw_pkg::VA_USED_W-1:0]   saved_next;
    logic [ptw_pkg::ADDR_W-1:0]      base;
    logic [ptw_pkg::ADDR_W-1:0]      frame;
    ptw_pkg::level_t                 up_level;

    function automatic logic [8:0] level_index(
        input logic [ptw_pkg::VA_USED_W-1:0] va,
        input ptw_pkg::level_t               lvl
    );
        logic [8:0] idx;
        case (lvl)
            ptw_pkg::LVL_PML4: idx = va[47:39];
            ptw_pkg::LVL_PDPT: idx = va[38:30];
            ptw_pkg::LVL_PD:   idx = va[29:21];
            ptw_pkg::LVL_PT:   idx = va[20:12];
            default:           idx = va[20:12];
        endcase
        return idx;
    endfunction

    assign base     = word.table_base[ptw_pkg::ADDR_W-1:0] & ~ptw_pkg::BASE_LOW_MASK;
    assign frame    = word.entry_data[ptw_pkg::ADDR_W-1:0] & ptw_pkg::PHYS_MASK
                      & ~ptw_pkg::PAGE_LOW_MASK;
    assign up_level = ptw_pkg::level_t'(level_reg + 2'd1);

    always_comb
    begin
        active_next           = active_reg;
        level_next            = level_reg;
        saved_next            = saved_reg;
        result.result_kind    = ptw_pkg::RESULT_DONE;
        result.read_address   = '0;
        result.target_address = '0;
        result.status         = ptw_pkg::ST_OK;
        result.large_mapping  = 1'b0;
        if (word.kind == ptw_pkg::KIND_REQUEST)
        begin
            if (active_reg)
            begin
                result.status = ptw_pkg::ST_BUSY;
            end
            else if (word.table_base == 64'd0 || word.virtual_address == 64'd0)
            begin
                result.status = ptw_pkg::ST_BAD_ARG;
            end
            else
            begin
                active_next         = 1'b1;
                level_next          = ptw_pkg::LVL_PML4;
                saved_next          = word.virtual_address[ptw_pkg::VA_USED_W-1:0];
                result.result_kind  = ptw_pkg::RESULT_READ;
                result.read_address = (base + ptw_pkg::ADDR_W'({level_index(
                    word.virtual_address[ptw_pkg::VA_USED_W-1:0],
                    ptw_pkg::LVL_PML4), 3'b000})) & ptw_pkg::PHYS_MASK;
            end
        end
        else if (!active_reg)
        begin
            result.status = ptw_pkg::ST_UNEXPECTED;
        end
        else if (!word.read_ok)
        begin
            active_next   = 1'b0;
            result.status = ptw_pkg::ST_READ_ERROR;
        end
        else if (!word.entry_data[0])
        begin
            active_next   = 1'b0;
            result.status = ptw_pkg::ST_NOT_PRESENT;
        end
        else if (level_reg == ptw_pkg::LVL_PD && word.entry_data[7])
        begin
            active_next           = 1'b0;
            result.large_mapping  = 1'b1;
            result.target_address = ((frame & ~ptw_pkg::LARGE_LOW_MASK)
                | ptw_pkg::ADDR_W'(saved_reg[20:0])) & ptw_pkg::PHYS_MASK;
        end
        else if (level_reg == ptw_pkg::LVL_PT)
        begin
            active_next           = 1'b0;
            result.target_address = (frame | ptw_pkg::ADDR_W'(saved_reg[11:0]))
                                    & ptw_pkg::PHYS_MASK;
        end
        else
        begin
            level_next          = up_level;
            result.result_kind  = ptw_pkg::RESULT_READ;
            result.read_address = (frame | ptw_pkg::ADDR_W'({level_index(saved_reg,
                                  up_level), 3'b000})) & ptw_pkg::PHYS_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            level_reg  <= ptw_pkg::LVL_PML4;
            saved_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            level_reg  <= level_next;
            saved_reg  <= saved_next;
        end
    end

endmodule

### rtl/core/ptw_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker result stage
// Registers one result word and presents it on the master side.
// ----------------------------------------------------------------------------
module ptw_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           word_valid,
    input  ptw_pkg::out_word_t             result,
    output logic                           advance,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);

    logic                 valid_reg;
    logic                 valid_next;
    ptw_pkg::out_word_t   result_reg;

    assign advance  = word_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.result_kind;
    assign m_tdata  = {4'b0000, result_reg.large_mapping, result_reg.status,
                       result_reg.target_address, result_reg.read_address};

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

### rtl/core/four_level_page_table_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker core
// Walks PML4, PDPT, PD and PT entries one memory response at a time.
// ----------------------------------------------------------------------------
// Every accepted word, a translation request or a memory read response,
// yields exactly one result word, either the next entry read request or the
// finished translation with its status. The core takes one word per cycle
// while the result side is not stalled. A word waits in the input register,
// then the step logic writes its result into the result register, and the
// walk state advances in that same cycle so the next word sees it.
// s_tready falls only while both registers hold a word and the result is
// not taken.
module four_level_page_table_walker_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: table_base, virtual_address, entry_data, read_ok.
    input  logic [ptw_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: kind.
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: read_address, target_address, status, large_mapping.
    output logic [ptw_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: result_kind.
    output logic                           m_tuser
);

    logic                 advance;
    logic                 word_valid;
    ptw_pkg::in_word_t    word;
    ptw_pkg::out_word_t   result;

    ptw_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    ptw_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (word),
        .result  (result)
    );

    ptw_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### rtl/core/ptw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker port checker
// Checks result word encoding and output stall behavior at the ports.
// ----------------------------------------------------------------------------
module ptw_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ptw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ptw_pkg::RESULT_READ |->
            m_tdata[111:52] == 60'd0)
        else $error("Read request carries nonzero finished fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ptw_pkg::RESULT_DONE |-> m_tdata[51:0] == 52'd0)
        else $error("Finished result carries a read address.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[107] |->
            m_tuser == ptw_pkg::RESULT_DONE && m_tdata[106:104] == ptw_pkg::ST_OK)
        else $error("Large mapping flagged on a word that is not a good finish.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[106:104] != ptw_pkg::ST_OK |-> m_tdata[103:52] == 52'd0)
        else $error("Faulted result carries a physical address.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result word changed.");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/tb_four_level_page_table_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker core testbench
// A short directed list comes first. It covers idle responses, zero arguments,
// busy requests, read errors, absent entries, full four-level walks and 2 MB
// pages. After it come about 1550 words, mostly complete walks with random
// entries and some noise between them. A walker model in the bench predicts
// every result word in order; the monitor compares each field. Both sides idle
// in random bursts, save in every third run of 150 words and the final stretch.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_core;

    import ptw_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_TAIL  = 120;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = KIND_REQUEST;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    in_word_t  word_queue[$];
    out_word_t expected_results[$];
    in_word_t  held_word;

    bit          stim_ready  = 1'b0;
    int          total_words = 0;
    int          words_taken = 0;
    int          send_gap    = 0;
    int          stall_left  = 0;
    int          errors      = 0;
    int          reads_seen  = 0;
    int          large_seen  = 0;
    int          done_by_status[0:7];

    logic        walk_busy  = 1'b0;
    level_t      walk_level = LVL_PML4;
    logic [63:0] walk_va    = '0;

    four_level_page_table_walker_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_nonzero();
        logic [63:0] v;
        v = rand64() >> $urandom_range(0, 63);
        if (v == 64'd0)
            v = 64'd1 << $urandom_range(0, 63);
        return v;
    endfunction

    function automatic logic [63:0] table_offset(logic [63:0] va, level_t lvl);
        logic [63:0] idx;
        idx = (va >> (39 - 9 * int'(lvl))) & 64'h1FF;
        return idx << 3;
    endfunction

    function automatic out_word_t finish_walk(logic [63:0] pa, status_t st, logic big_page);
        out_word_t r;
        r.result_kind    = RESULT_DONE;
        r.read_address   = '0;
        r.target_address = ADDR_W'(pa) & PHYS_MASK;
        r.status         = st;
        r.large_mapping  = big_page;
        return r;
    endfunction

    function automatic out_word_t issue_read(logic [63:0] addr);
        out_word_t r;
        r.result_kind    = RESULT_READ;
        r.read_address   = ADDR_W'(addr) & PHYS_MASK;
        r.target_address = '0;
        r.status         = ST_OK;
        r.large_mapping  = 1'b0;
        return r;
    endfunction

    // Advances the walker model by one accepted word and returns its result.
    function out_word_t translate_step(in_word_t w);
        logic [63:0] frame;
        if (w.kind == KIND_REQUEST)
        begin
            if (walk_busy)
                return finish_walk(64'd0, ST_BUSY, 1'b0);
            if (w.table_base == 64'd0 || w.virtual_address == 64'd0)
                return finish_walk(64'd0, ST_BAD_ARG, 1'b0);
            walk_busy  = 1'b1;
            walk_level = LVL_PML4;
            walk_va    = w.virtual_address;
            return issue_read((w.table_base & ~64'hF) +
                              table_offset(w.virtual_address, LVL_PML4));
        end
        if (!walk_busy)
            return finish_walk(64'd0, ST_UNEXPECTED, 1'b0);
        if (!w.read_ok)
        begin
            walk_busy = 1'b0;
            return finish_walk(64'd0, ST_READ_ERROR, 1'b0);
        end
        if (!w.entry_data[0])
        begin
            walk_busy = 1'b0;
            return finish_walk(64'd0, ST_NOT_PRESENT, 1'b0);
        end
        frame = w.entry_data & {12'd0, PHYS_MASK} & ~64'hFFF;
        if (walk_level == LVL_PD && w.entry_data[7])
        begin
            walk_busy = 1'b0;
            return finish_walk((frame & ~64'h1FFFFF) | (walk_va & 64'h1FFFFF), ST_OK, 1'b1);
        end
        if (walk_level == LVL_PT)
        begin
            walk_busy = 1'b0;
            return finish_walk(frame | (walk_va & 64'hFFF), ST_OK, 1'b0);
        end
        walk_level = level_t'(walk_level + 2'd1);
        return issue_read(frame + table_offset(walk_va, walk_level));
    endfunction

    task automatic add_request(logic [63:0] base, logic [63:0] va);
        in_word_t w;
        w.kind            = KIND_REQUEST;
        w.table_base      = base;
        w.virtual_address = va;
        w.entry_data      = rand64();
        w.read_ok         = $urandom_range(0, 1);
        word_queue.push_back(w);
    endtask

    task automatic add_response(logic [63:0] entry, logic ok);
        in_word_t w;
        w.kind            = KIND_RESPONSE;
        w.table_base      = rand64();
        w.virtual_address = rand64();
        w.entry_data      = entry;
        w.read_ok         = ok;
        word_queue.push_back(w);
    endtask

    // Queues a request, the responses that carry it to its end and some stray requests.
    task automatic add_walk();
        int          lvl;
        int          pick;
        bit          ended;
        logic [63:0] entry;
        add_request(rand_nonzero(), rand_nonzero());
        lvl   = 0;
        ended = 1'b0;
        while (!ended)
        begin
            if ($urandom_range(0, 19) == 0)
                add_request(rand64(), rand64());
            pick  = $urandom_range(0, 99);
            entry = rand64();
            if (pick < 3)
            begin
                add_response(entry, 1'b0);
                ended = 1'b1;
            end
            else if (pick < 7)
            begin
                entry[0] = 1'b0;
                add_response(entry, 1'b1);
                ended = 1'b1;
            end
            else
            begin
                entry[0] = 1'b1;
                if (lvl == 2)
                    entry[7] = ($urandom_range(0, 2) == 0);
                if ((lvl == 2 && entry[7]) || lvl == 3)
                    ended = 1'b1;
                add_response(entry, 1'b1);
                lvl++;
            end
        end
    endtask

    function bit idling_off();
        return (stim_ready && word_queue.size() < QUIET_TAIL) ||
               ((words_taken / 150) % 3 == 2);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_REQUEST;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(translate_step(held_word));
                words_taken <= words_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (stim_ready && word_queue.size() != 0)
                begin
                    held_word = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, held_word.read_ok, held_word.entry_data,
                                 held_word.virtual_address, held_word.table_base};
                    s_tuser  <= held_word.kind;
                    if (!idling_off() && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 19);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.result_kind    = m_tuser;
                got.read_address   = m_tdata[51:0];
                got.target_address = m_tdata[103:52];
                got.status         = status_t'(m_tdata[106:104]);
                got.large_mapping  = m_tdata[107];
                if (got.result_kind == RESULT_READ)
                    reads_seen++;
                else
                    done_by_status[got.status]++;
                if (got.result_kind == RESULT_DONE && got.large_mapping)
                    large_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result word: kind %0d status %0d",
                                 got.result_kind, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.result_kind !== want.result_kind ||
                        got.read_address !== want.read_address ||
                        got.target_address !== want.target_address ||
                        got.status !== want.status ||
                        got.large_mapping !== want.large_mapping)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("Mismatch: expected kind %0d read %h phys %h st %0d lg %0d",
                                     want.result_kind, want.read_address,
                                     want.target_address, want.status,
                                     want.large_mapping);
                            $display("          got      kind %0d read %h phys %h st %0d lg %0d",
                                     got.result_kind, got.read_address,
                                     got.target_address, got.status,
                                     got.large_mapping);
                        end
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (!idling_off() && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 18);
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int pick;
        foreach (done_by_status[i])
            done_by_status[i] = 0;

        add_response(rand64() | 64'd1, 1'b1);
        add_response(rand64(), 1'b0);
        add_request(64'd0, rand_nonzero());
        add_request(rand_nonzero(), 64'd0);
        add_request(64'd0, 64'd0);
        add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(rand_nonzero(), rand_nonzero());
        add_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(64'd1, rand_nonzero());
        add_response(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        add_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_response(64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
        add_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_request(64'h0000_0000_0000_1000, 64'h0000_0000_0000_0001);
        add_response(64'h0000_0000_0000_0001, 1'b1);
        add_response(64'h0000_0000_0000_0081, 1'b1);
        add_response(64'h000F_FFFF_FFE0_0081, 1'b1);
        add_request(rand_nonzero(), rand64() | 64'd1);
        add_response(rand64() | 64'd1, 1'b1);
        add_response(rand64() | 64'd1, 1'b1);
        add_response(rand64() | 64'h81, 1'b1);

        while (word_queue.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                add_walk();
            end
            else if (pick < 83)
            begin
                add_response(rand64(), $urandom_range(0, 1));
            end
            else if (pick < 91)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_request(64'd0, rand64());
                else
                    add_request(rand64(), 64'd0);
            end
            else
            begin
                // A stray word may open a walk; the failed read closes it either way.
                add_response(rand64(), $urandom_range(0, 1));
                if ($urandom_range(0, 1) == 0)
                    add_request(rand64(), rand64());
                add_response(rand64(), 1'b0);
            end
        end
        total_words = word_queue.size();
        stim_ready  = 1'b1;

        @(posedge rst_n);
        while (words_taken != total_words)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d words: %0d entry reads, %0d good translations, %0d large.",
                 total_words, reads_seen, done_by_status[ST_OK], large_seen);
        $display("Faults: bad arg %0d, absent %0d, read err %0d, busy %0d, idle resp %0d.",
                 done_by_status[ST_BAD_ARG], done_by_status[ST_NOT_PRESENT],
                 done_by_status[ST_READ_ERROR], done_by_status[ST_BUSY],
                 done_by_status[ST_UNEXPECTED]);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
